// File: sv/tpsa_pkg.sv
package tpsa_pkg;

	localparam int POOL_SIZE_W = 5;
	localparam int OWNER_W     = 16;
	localparam int CLASS_W     = 2;
	localparam int STATUS_W    = 2;
	localparam int POOL_W      = 2;
	localparam int SLOT_W      = 4;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 5'd16;

	localparam logic REG_POOL_SIZE = 1'b0;

	localparam logic FUNC_ENTER = 1'b0;
	localparam logic FUNC_EXIT  = 1'b1;

	localparam logic [CLASS_W-1:0] CLS_A   = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_B   = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_C   = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_BAD = 2'd3;

	localparam logic [POOL_W-1:0] POOL_B = 2'd1;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_GRANT = 5'b00010,
		S_RD    = 5'b00100,
		S_CMP   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage

// File: sv/tpsa_if.sv
interface tpsa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [tpsa_pkg::CLASS_W-1:0] vehicle_class;
	logic [tpsa_pkg::OWNER_W-1:0] owner_id;

	modport source(output valid, func, vehicle_class, owner_id, input ready);
	modport sink(input valid, func, vehicle_class, owner_id, output ready);
endinterface

interface tpsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tpsa_pkg::STATUS_W-1:0] status;
	logic [tpsa_pkg::POOL_W-1:0]   pool;
	logic [tpsa_pkg::SLOT_W-1:0]   slot_index;
	logic                          waiting_granted;
	logic [tpsa_pkg::OWNER_W-1:0]  waiting_owner;
	logic [tpsa_pkg::POOL_W-1:0]   waiting_pool;
	logic [tpsa_pkg::SLOT_W-1:0]   waiting_slot;

	modport source(output valid, status, pool, slot_index, waiting_granted, waiting_owner,
		waiting_pool, waiting_slot, input ready);
	modport sink(input valid, status, pool, slot_index, waiting_granted, waiting_owner,
		waiting_pool, waiting_slot, output ready);
endinterface

// File: sv/typed_pool_slot_allocator_core.sv
// Exit: the release scan passes each used slot through S_RD and S_CMP for the registered
//   owner-table read, then the waiting request is retried.
// Throughput: one request at a time; the next is taken once the finished response has
//   entered the output register, where it may still wait for rsp.ready.
// Reset: used marks, waiting request and state machine clear at once; pool_size returns
//   to 16; the owner table is not cleared.
module typed_pool_slot_allocator_core #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tpsa_req_if.sink                    req,
	tpsa_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpsa_pkg::APB_AW-1:0] paddr,
	input  logic [tpsa_pkg::APB_DW-1:0] pwdata,
	output logic [tpsa_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int NSLOT = 3 * SLOTS;
	localparam int AW    = $clog2(NSLOT);
	localparam int IW    = $clog2(SLOTS + 1);
	localparam int IXW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = ((IW > tpsa_pkg::POOL_SIZE_W) ? IW : tpsa_pkg::POOL_SIZE_W) + 1;

	logic [tpsa_pkg::POOL_SIZE_W-1:0] pool_size;

	tpsa_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pool_size (pool_size)
	);

	tpsa_pkg::state_t st_q;

	logic [NSLOT-1:0]                 used_q;
	logic [tpsa_pkg::OWNER_W-1:0]     owner_mem [NSLOT];
	logic [tpsa_pkg::OWNER_W-1:0]     rd_q;

	logic [tpsa_pkg::CLASS_W-1:0]     cls_q;
	logic [tpsa_pkg::OWNER_W-1:0]     id_q;
	logic                             retry_q;
	logic                             phase_q;
	logic [IW-1:0]                    idx_q;

	logic                             wait_valid_q;
	logic [tpsa_pkg::OWNER_W-1:0]     wait_id_q;
	logic [tpsa_pkg::CLASS_W-1:0]     wait_cls_q;

	logic [tpsa_pkg::STATUS_W-1:0]    status_q;
	logic [tpsa_pkg::POOL_W-1:0]      pool_q;
	logic [tpsa_pkg::SLOT_W-1:0]      slot_q;
	logic                             wg_q;
	logic [tpsa_pkg::OWNER_W-1:0]     wo_q;
	logic [tpsa_pkg::POOL_W-1:0]      wp_q;
	logic [tpsa_pkg::SLOT_W-1:0]      ws_q;

	logic                             ov_q;
	logic [tpsa_pkg::STATUS_W-1:0]    ostatus_q;
	logic [tpsa_pkg::POOL_W-1:0]      opool_q;
	logic [tpsa_pkg::SLOT_W-1:0]      oslot_q;
	logic                             owg_q;
	logic [tpsa_pkg::OWNER_W-1:0]     owo_q;
	logic [tpsa_pkg::POOL_W-1:0]      owp_q;
	logic [tpsa_pkg::SLOT_W-1:0]      ows_q;

	logic [CW-1:0]                    n_cw;
	logic [IW-1:0]                    n;
	logic [tpsa_pkg::POOL_W-1:0]      pl;
	logic                             has_fb;
	logic                             end_pool;
	logic [AW-1:0]                    addr;
	logic [IW+tpsa_pkg::SLOT_W-1:0]   idx_ext;
	logic [tpsa_pkg::SLOT_W-1:0]      slot4;
	logic                             grant_hit;
	logic [tpsa_pkg::OWNER_W-1:0]     grant_id;
	logic                             req_acc;

	assign n_cw     = (CW'(pool_size) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(pool_size);
	assign n        = n_cw[IW-1:0];
	assign pl       = phase_q ? tpsa_pkg::POOL_B : cls_q;
	assign has_fb   = (cls_q == tpsa_pkg::CLS_A) || (cls_q == tpsa_pkg::CLS_C);
	assign end_pool = (idx_q >= n);
	assign addr     = AW'(pl) * AW'(SLOTS) + AW'(idx_q[IXW-1:0]);
	assign idx_ext  = {{tpsa_pkg::SLOT_W{1'b0}}, idx_q};
	assign slot4    = idx_ext[tpsa_pkg::SLOT_W-1:0];
	assign grant_hit = (st_q == tpsa_pkg::S_GRANT) && !end_pool && !used_q[addr];
	assign grant_id = retry_q ? wait_id_q : id_q;
	assign req_acc  = req.valid && req.ready;

	assign req.ready = (st_q == tpsa_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (grant_hit) begin
			owner_mem[addr] <= grant_id;
		end
		rd_q <= owner_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= tpsa_pkg::S_IDLE;
			used_q       <= '0;
			cls_q        <= '0;
			id_q         <= '0;
			retry_q      <= 1'b0;
			phase_q      <= 1'b0;
			idx_q        <= '0;
			wait_valid_q <= 1'b0;
			wait_id_q    <= '0;
			wait_cls_q   <= '0;
			status_q     <= '0;
			pool_q       <= '0;
			slot_q       <= '0;
			wg_q         <= 1'b0;
			wo_q         <= '0;
			wp_q         <= '0;
			ws_q         <= '0;
		end else begin
			case (st_q)
				tpsa_pkg::S_IDLE: begin
					if (req_acc) begin
						id_q     <= req.owner_id;
						phase_q  <= 1'b0;
						idx_q    <= '0;
						pool_q   <= '0;
						slot_q   <= '0;
						wg_q     <= 1'b0;
						wo_q     <= '0;
						wp_q     <= '0;
						ws_q     <= '0;
						if (req.func == tpsa_pkg::FUNC_ENTER) begin
							cls_q   <= req.vehicle_class;
							retry_q <= 1'b0;
							if (req.vehicle_class == tpsa_pkg::CLS_BAD) begin
								status_q <= tpsa_pkg::STAT_INVALID;
								st_q     <= tpsa_pkg::S_DONE;
							end else begin
								status_q <= tpsa_pkg::STAT_OK;
								st_q     <= tpsa_pkg::S_GRANT;
							end
						end else if (req.vehicle_class == tpsa_pkg::CLS_BAD) begin
							status_q <= tpsa_pkg::STAT_MISS;
							if (wait_valid_q) begin
								cls_q   <= wait_cls_q;
								retry_q <= 1'b1;
								st_q    <= tpsa_pkg::S_GRANT;
							end else begin
								cls_q   <= req.vehicle_class;
								retry_q <= 1'b0;
								st_q    <= tpsa_pkg::S_DONE;
							end
						end else begin
							cls_q    <= req.vehicle_class;
							retry_q  <= 1'b0;
							status_q <= tpsa_pkg::STAT_OK;
							st_q     <= tpsa_pkg::S_RD;
						end
					end
				end
				tpsa_pkg::S_GRANT: begin
					if (end_pool) begin
						if (!phase_q && has_fb) begin
							phase_q <= 1'b1;
							idx_q   <= '0;
						end else begin
							if (!retry_q) begin
								status_q     <= tpsa_pkg::STAT_MISS;
								wait_valid_q <= 1'b1;
								wait_id_q    <= id_q;
								wait_cls_q   <= cls_q;
							end
							st_q <= tpsa_pkg::S_DONE;
						end
					end else if (!used_q[addr]) begin
						used_q[addr] <= 1'b1;
						if (retry_q) begin
							wait_valid_q <= 1'b0;
							wg_q         <= 1'b1;
							wo_q         <= wait_id_q;
							wp_q         <= pl;
							ws_q         <= slot4;
						end else begin
							status_q <= tpsa_pkg::STAT_OK;
							pool_q   <= pl;
							slot_q   <= slot4;
						end
						st_q <= tpsa_pkg::S_DONE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				tpsa_pkg::S_RD: begin
					if (end_pool) begin
						if (!phase_q && has_fb) begin
							phase_q <= 1'b1;
							idx_q   <= '0;
						end else begin
							status_q <= tpsa_pkg::STAT_MISS;
							if (wait_valid_q) begin
								cls_q   <= wait_cls_q;
								retry_q <= 1'b1;
								phase_q <= 1'b0;
								idx_q   <= '0;
								st_q    <= tpsa_pkg::S_GRANT;
							end else begin
								st_q <= tpsa_pkg::S_DONE;
							end
						end
					end else if (used_q[addr]) begin
						st_q <= tpsa_pkg::S_CMP;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				tpsa_pkg::S_CMP: begin
					if (rd_q == id_q) begin
						used_q[addr] <= 1'b0;
						status_q     <= tpsa_pkg::STAT_OK;
						if (wait_valid_q) begin
							cls_q   <= wait_cls_q;
							retry_q <= 1'b1;
							phase_q <= 1'b0;
							idx_q   <= '0;
							st_q    <= tpsa_pkg::S_GRANT;
						end else begin
							st_q <= tpsa_pkg::S_DONE;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q  <= tpsa_pkg::S_RD;
					end
				end
				tpsa_pkg::S_DONE: begin
					if (!ov_q || rsp.ready) begin
						st_q <= tpsa_pkg::S_IDLE;
					end
				end
				default: begin
					st_q <= tpsa_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (st_q == tpsa_pkg::S_DONE && (!ov_q || rsp.ready)) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == tpsa_pkg::S_DONE && (!ov_q || rsp.ready)) begin
			ostatus_q <= status_q;
			opool_q   <= pool_q;
			oslot_q   <= slot_q;
			owg_q     <= wg_q;
			owo_q     <= wo_q;
			owp_q     <= wp_q;
			ows_q     <= ws_q;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = ostatus_q;
	assign rsp.pool            = opool_q;
	assign rsp.slot_index      = oslot_q;
	assign rsp.waiting_granted = owg_q;
	assign rsp.waiting_owner   = owo_q;
	assign rsp.waiting_pool    = owp_q;
	assign rsp.waiting_slot    = ows_q;

`ifndef SYNTHESIS
	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		grant_hit |=> used_q[$past(addr)])
		else $error("granted slot not marked used");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tpsa_pkg::S_CMP) |-> ($past(st_q) == tpsa_pkg::S_RD))
		else $error("owner compare without a table read");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IW'(SLOTS))
		else $error("slot index beyond pool");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == tpsa_pkg::STAT_INVALID) |->
		(!rsp.waiting_granted && rsp.pool == '0 && rsp.slot_index == '0))
		else $error("invalid-class beat carries a grant");
`endif

endmodule

// File: sv/tpsa_apb_regs.sv
module tpsa_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tpsa_pkg::APB_AW-1:0]      paddr,
	input  logic [tpsa_pkg::APB_DW-1:0]      pwdata,
	output logic [tpsa_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	output logic [tpsa_pkg::POOL_SIZE_W-1:0] pool_size
);

	logic [tpsa_pkg::POOL_SIZE_W-1:0] pool_size_q;
	logic                             hit_ps;

	assign hit_ps = (paddr[2] == tpsa_pkg::REG_POOL_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= tpsa_pkg::POOL_SIZE_RST;
		end else if (psel && penable && pwrite && hit_ps) begin
			pool_size_q <= pwdata[tpsa_pkg::POOL_SIZE_W-1:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = hit_ps ? tpsa_pkg::APB_DW'(pool_size_q) : '0;
	assign pool_size = pool_size_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tpsa_pkg::*;

	localparam int SLOTS       = 16;
	localparam int LAST_CYCLES = 6*SLOTS + 20;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POOL_W-1:0]   pool;
		logic [SLOT_W-1:0]   slot_index;
		logic                waiting_granted;
		logic [OWNER_W-1:0]  waiting_owner;
		logic [POOL_W-1:0]   waiting_pool;
		logic [SLOT_W-1:0]   waiting_slot;
	} slot_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tpsa_req_if req();
	tpsa_rsp_if rsp();

	typed_pool_slot_allocator_core #(.SLOTS(SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic                   slot_used_m  [3*SLOTS];
	logic [OWNER_W-1:0]     slot_owner_m [3*SLOTS];
	logic                   wait_valid_m;
	logic [OWNER_W-1:0]     wait_id_m;
	logic [CLASS_W-1:0]     wait_cls_m;
	logic [POOL_SIZE_W-1:0] pool_size_m;

	slot_result_t pending_results[$];
	int           errors          = 0;
	int           cycle_count     = 0;
	int           rsp_hold_cycles = 0;
	bit           no_gaps         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int eff_size();
		return (pool_size_m > SLOTS) ? SLOTS : int'(pool_size_m);
	endfunction

	function automatic bit claim_slot(input logic [CLASS_W-1:0] cls, input logic [OWNER_W-1:0] id,
		output logic [POOL_W-1:0] gp, output logic [SLOT_W-1:0] gi);
		int order [2];
		int n;
		n = eff_size();
		order[0] = cls;
		order[1] = (cls == CLS_A || cls == CLS_C) ? int'(POOL_B) : 3;
		gp = '0;
		gi = '0;
		for (int k = 0; k < 2; k++) begin
			if (order[k] > 2) continue;
			for (int i = 0; i < n; i++) begin
				if (!slot_used_m[order[k]*SLOTS + i]) begin
					slot_used_m[order[k]*SLOTS + i] = 1'b1;
					slot_owner_m[order[k]*SLOTS + i] = id;
					gp = POOL_W'(order[k]);
					gi = SLOT_W'(i);
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic bit free_slot(input logic [CLASS_W-1:0] cls, input logic [OWNER_W-1:0] id);
		int order [2];
		int n;
		n = eff_size();
		if (cls == CLS_BAD) return 1'b0;
		order[0] = cls;
		order[1] = (cls == CLS_A || cls == CLS_C) ? int'(POOL_B) : 3;
		for (int k = 0; k < 2; k++) begin
			if (order[k] > 2) continue;
			for (int i = 0; i < n; i++) begin
				if (slot_used_m[order[k]*SLOTS + i] && slot_owner_m[order[k]*SLOTS + i] == id) begin
					slot_used_m[order[k]*SLOTS + i] = 1'b0;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic slot_result_t predict_slot_result(input logic f, input logic [CLASS_W-1:0] c,
		input logic [OWNER_W-1:0] id);
		slot_result_t       r;
		logic [POOL_W-1:0]  gp;
		logic [SLOT_W-1:0]  gi;
		r = '0;
		if (f == FUNC_ENTER) begin
			if (c == CLS_BAD) begin
				r.status = STAT_INVALID;
			end else if (claim_slot(c, id, gp, gi)) begin
				r.status = STAT_OK;
				r.pool = gp;
				r.slot_index = gi;
			end else begin
				r.status = STAT_MISS;
				wait_valid_m = 1'b1;
				wait_id_m = id;
				wait_cls_m = c;
			end
		end else begin
			r.status = free_slot(c, id) ? STAT_OK : STAT_MISS;
			if (wait_valid_m && claim_slot(wait_cls_m, wait_id_m, gp, gi)) begin
				wait_valid_m = 1'b0;
				r.waiting_granted = 1'b1;
				r.waiting_owner = wait_id_m;
				r.waiting_pool = gp;
				r.waiting_slot = gi;
			end
		end
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_rsp
		slot_result_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: response beat with none pending, expected none, actual status %0h",
					$time, rsp.status);
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, rsp.status);
				compare_field("pool", want.pool, rsp.pool);
				compare_field("slot_index", want.slot_index, rsp.slot_index);
				compare_field("waiting_granted", want.waiting_granted, rsp.waiting_granted);
				compare_field("waiting_owner", want.waiting_owner, rsp.waiting_owner);
				compare_field("waiting_pool", want.waiting_pool, rsp.waiting_pool);
				compare_field("waiting_slot", want.waiting_slot, rsp.waiting_slot);
			end
		end
	end

	initial begin : rsp_drive
		int stall;
		stall = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp.ready = 1'b0;
				repeat (rsp_hold_cycles - 1) @(negedge clk);
				rsp_hold_cycles = 0;
			end else if (no_gaps) begin
				rsp.ready = 1'b1;
			end else if (stall > 0) begin
				rsp.ready = 1'b0;
				stall--;
			end else begin
				rsp.ready = 1'b1;
				if ($urandom_range(0, 99) < 15) stall = pick_gap();
			end
		end
	end

	task automatic send_request(input logic f, input logic [CLASS_W-1:0] c,
		input logic [OWNER_W-1:0] id);
		int gap;
		@(negedge clk);
		req.valid = 1'b1;
		req.func = f;
		req.vehicle_class = c;
		req.owner_id = id;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(predict_slot_result(f, c, id));
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_pool_size_reg();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {REG_POOL_SIZE, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[POOL_SIZE_W-1:0] !== pool_size_m) begin
			errors++;
			$display("%0t: pool_size readback, expected %0d, actual %0d", $time, pool_size_m,
				prdata[POOL_SIZE_W-1:0]);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_pool_size(input logic [APB_DW-1:0] value);
		drain_results();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_POOL_SIZE, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pool_size_m = value[POOL_SIZE_W-1:0];
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		check_pool_size_reg();
	endtask

	task automatic send_random_request(input int enter_pct);
		int                 r;
		int                 a;
		int                 used_q[$];
		logic               f;
		logic [CLASS_W-1:0] c;
		logic [OWNER_W-1:0] id;
		for (int i = 0; i < 3*SLOTS; i++) if (slot_used_m[i]) used_q.push_back(i);
		r = $urandom_range(0, 99);
		f = FUNC_ENTER;
		c = CLASS_W'($urandom_range(0, 2));
		id = OWNER_W'($urandom);
		if (r < 8) begin
			f = $urandom_range(0, 1) ? FUNC_EXIT : FUNC_ENTER;
			c = CLASS_W'($urandom_range(0, 3));
		end else if (r < 8 + enter_pct) begin
			if (used_q.size() != 0 && $urandom_range(0, 3) == 0)
				id = slot_owner_m[used_q[$urandom_range(0, used_q.size() - 1)]];
		end else begin
			f = FUNC_EXIT;
			if (used_q.size() != 0 && $urandom_range(0, 9) != 0) begin
				a = used_q[$urandom_range(0, used_q.size() - 1)];
				id = slot_owner_m[a];
				c = (a / SLOTS == POOL_B) ? CLASS_W'($urandom_range(0, 2)) : CLASS_W'(a / SLOTS);
			end
		end
		send_request(f, c, id);
	endtask

	task automatic test_directed_grants();
		write_pool_size(2);
		send_request(FUNC_ENTER, CLS_A, 16'h0000);
		send_request(FUNC_ENTER, CLS_A, 16'hFFFF);
		send_request(FUNC_ENTER, CLS_A, 16'h1234);
		send_request(FUNC_ENTER, CLS_C, 16'hAAAA);
		send_request(FUNC_ENTER, CLS_C, 16'h5555);
		send_request(FUNC_ENTER, CLS_C, 16'h0F0F);
		send_request(FUNC_ENTER, CLS_B, 16'hF0F0);
		send_request(FUNC_ENTER, CLS_A, 16'h1111);
		send_request(FUNC_ENTER, CLS_BAD, 16'h7777);
		send_request(FUNC_EXIT, CLS_BAD, 16'hFFFF);
		send_request(FUNC_EXIT, CLS_A, 16'hFFFF);
		send_request(FUNC_EXIT, CLS_C, 16'h1234);
		send_request(FUNC_EXIT, CLS_B, 16'h9999);
		send_request(FUNC_ENTER, CLS_B, 16'hF0F0);
		send_request(FUNC_EXIT, CLS_A, 16'h0000);
		drain_results();
	endtask

	task automatic test_pool_size_edges();
		write_pool_size(0);
		send_request(FUNC_ENTER, CLS_C, 16'hBEEF);
		send_request(FUNC_EXIT, CLS_A, 16'h1111);
		write_pool_size(31);
		send_request(FUNC_EXIT, CLS_B, 16'h4321);
		write_pool_size(1);
		send_request(FUNC_EXIT, CLS_A, 16'h1111);
		send_request(FUNC_ENTER, CLS_A, 16'h2222);
		send_request(FUNC_ENTER, CLS_A, 16'h3333);
		write_pool_size(2);
		send_request(FUNC_EXIT, CLS_C, 16'hAAAA);
		send_request(FUNC_EXIT, CLS_A, 16'h1111);
		drain_results();
	endtask

	task automatic test_random_mix();
		int sizes  [8];
		int counts [8];
		int enters [8];
		sizes  = '{1, 3, 16, 2, 31, 0, 4, 5};
		counts = '{80, 120, 180, 90, 60, 20, 130, 90};
		enters = '{50, 50, 70, 50, 65, 50, 50, 50};
		for (int p = 0; p < 8; p++) begin
			write_pool_size(sizes[p]);
			no_gaps = (p == 7);
			repeat (counts[p]) send_random_request(enters[p]);
			drain_results();
			no_gaps = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		write_pool_size(3);
		no_gaps = 1'b1;
		rsp_hold_cycles = 400;
		repeat (40) send_random_request(50);
		drain_results();
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_ENTER;
		req.vehicle_class = CLS_A;
		req.owner_id = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < 3*SLOTS; i++) begin
			slot_used_m[i] = 1'b0;
			slot_owner_m[i] = '0;
		end
		wait_valid_m = 1'b0;
		wait_id_m = '0;
		wait_cls_m = CLS_A;
		pool_size_m = POOL_SIZE_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_pool_size_reg();
		test_directed_grants();
		test_pool_size_edges();
		test_random_mix();
		test_backpressure();

		drain_results();
		repeat (LAST_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
